@@ design/csm_pkg.sv @@
// Package for the checked stack machine: sizes, request and opcode codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
package csm_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned VAL_W       = 31;
  localparam int unsigned CNT_W       = $clog2(DATA_W);

  localparam logic [VAL_W-1:0] LIMIT_RESET = 31'd1000000000;

  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_EXEC  = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [3:0] OP_NUM = 4'd0;
  localparam logic [3:0] OP_POP = 4'd1;
  localparam logic [3:0] OP_INV = 4'd2;
  localparam logic [3:0] OP_DUP = 4'd3;
  localparam logic [3:0] OP_SWP = 4'd4;
  localparam logic [3:0] OP_ADD = 4'd5;
  localparam logic [3:0] OP_SUB = 4'd6;
  localparam logic [3:0] OP_MUL = 4'd7;
  localparam logic [3:0] OP_DIV = 4'd8;
  localparam logic [3:0] OP_MOD = 4'd9;

  typedef struct packed {
    logic start_run;
    logic set_err;
    logic push;
    logic push_tos;
    logic pop;
    logic inv;
    logic swap;
    logic add;
    logic sub;
    logic mul;
    logic div_start;
    logic div_fin;
    logic is_mod;
    logic commit;
    logic emit;
  } csm_cmd_t;

  typedef struct packed {
    logic depth_zero;
    logic depth_lt2;
    logic depth_full;
    logic err;
    logic b_zero;
    logic div_done;
    logic out_busy;
  } csm_status_t;

endpackage

@@ design/csm_div.sv @@
// Iterative unsigned 32-bit divider, one quotient bit per cycle.
// Depends on csm_pkg.
module csm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [csm_pkg::DATA_W-1:0] dividend_i,
  input  logic [csm_pkg::DATA_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [csm_pkg::DATA_W-1:0] quo_o,
  output logic [csm_pkg::DATA_W-1:0] rem_o
);

  logic                       busy_q, done_q;
  logic [csm_pkg::CNT_W-1:0]  cnt_q;
  logic [csm_pkg::DATA_W-1:0] rem_q, quo_q, dvs_q;
  logic [csm_pkg::DATA_W:0]   trial;
  logic                       qbit;

  assign trial = {rem_q, quo_q[csm_pkg::DATA_W-1]} - {1'b0, dvs_q};
  assign qbit  = ~trial[csm_pkg::DATA_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == csm_pkg::CNT_W'(csm_pkg::DATA_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? trial[csm_pkg::DATA_W-1:0]
                    : {rem_q[csm_pkg::DATA_W-2:0], quo_q[csm_pkg::DATA_W-1]};
      quo_q <= {quo_q[csm_pkg::DATA_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ design/csm_dpath.sv @@
// Datapath: stack memory with a cached top entry, depth and error flag,
// arithmetic and limit check, limit register and the output register.
// Depends on csm_pkg and csm_div.
module csm_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  csm_pkg::csm_cmd_t                 cmd_i,
  input  logic                              load_i,
  input  logic [csm_pkg::VAL_W-1:0]         operand_i,
  input  logic                              cfg_we_i,
  input  logic [csm_pkg::VAL_W-1:0]         cfg_wdata_i,
  input  logic                              m_tready_i,
  output csm_pkg::csm_status_t              status_o,
  output logic                              m_tvalid_o,
  output logic [csm_pkg::DATA_W-1:0]        m_tdata_o
);

  localparam int unsigned W2 = 2 * csm_pkg::DATA_W;

  logic [csm_pkg::DATA_W-1:0]  stack_mem [csm_pkg::STACK_DEPTH];
  logic [csm_pkg::DEPTH_W-1:0] depth_q, depth_d, depth_m1, depth_m2;
  logic                        err_q, err_d;
  logic [csm_pkg::DATA_W-1:0]  tos_q, tos_d, rd_q;
  logic [csm_pkg::VAL_W-1:0]   opnd_q, limit_q;
  logic signed [W2-1:0]        res_q, res_d, res_abs, prod;
  logic                        out_valid_q;
  logic [csm_pkg::DATA_W-1:0]  out_data_q;
  logic                        wr_en;
  logic [csm_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
  logic [csm_pkg::DATA_W-1:0]  wr_data, opnd_ext, a_mag, b_mag, quo, rem, dmag;
  logic                        over, div_done, dneg, fail;

  assign depth_m1 = depth_q - csm_pkg::DEPTH_W'(1);
  assign depth_m2 = depth_q - csm_pkg::DEPTH_W'(2);
  assign rd_addr  = depth_m2[csm_pkg::ADDR_W-1:0];
  assign opnd_ext = {opnd_q[csm_pkg::VAL_W-1], opnd_q};

  // The second entry (below the cached top) is read when the item is taken.
  always_ff @(posedge clk_i) begin
    if (wr_en) stack_mem[wr_addr] <= wr_data;
    if (load_i) rd_q <= stack_mem[rd_addr];
  end

  assign a_mag = rd_q[csm_pkg::DATA_W-1] ? -rd_q : rd_q;
  assign b_mag = tos_q[csm_pkg::DATA_W-1] ? -tos_q : tos_q;

  csm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (a_mag),
    .divisor_i  (b_mag),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  assign prod    = $signed(rd_q) * $signed(tos_q);
  assign dmag    = cmd_i.is_mod ? rem : quo;
  assign dneg    = cmd_i.is_mod ? rd_q[csm_pkg::DATA_W-1]
                                : rd_q[csm_pkg::DATA_W-1] ^ tos_q[csm_pkg::DATA_W-1];
  assign res_abs = res_q[W2-1] ? -res_q : res_q;
  assign over    = res_abs > $signed({{(W2 - csm_pkg::VAL_W){1'b0}}, limit_q});

  always_comb begin
    res_d = res_q;
    if (cmd_i.add) begin
      res_d = $signed({{csm_pkg::DATA_W{rd_q[csm_pkg::DATA_W-1]}}, rd_q})
            + $signed({{csm_pkg::DATA_W{tos_q[csm_pkg::DATA_W-1]}}, tos_q});
    end
    if (cmd_i.sub) begin
      res_d = $signed({{csm_pkg::DATA_W{rd_q[csm_pkg::DATA_W-1]}}, rd_q})
            - $signed({{csm_pkg::DATA_W{tos_q[csm_pkg::DATA_W-1]}}, tos_q});
    end
    if (cmd_i.mul) res_d = prod;
    if (cmd_i.div_fin) begin
      res_d = dneg ? -$signed({{csm_pkg::DATA_W{1'b0}}, dmag})
                   : $signed({{csm_pkg::DATA_W{1'b0}}, dmag});
    end
  end

  always_comb begin
    depth_d = depth_q;
    err_d   = err_q;
    tos_d   = tos_q;
    wr_en   = 1'b0;
    wr_addr = depth_m1[csm_pkg::ADDR_W-1:0];
    wr_data = tos_q;
    if (cmd_i.start_run) begin
      depth_d = csm_pkg::DEPTH_W'(1);
      err_d   = 1'b0;
      tos_d   = opnd_ext;
    end
    if (cmd_i.set_err) err_d = 1'b1;
    if (cmd_i.push) begin
      // The old top moves into memory; nothing moves on an empty stack.
      wr_en   = (depth_q != '0);
      depth_d = depth_q + csm_pkg::DEPTH_W'(1);
      if (!cmd_i.push_tos) tos_d = opnd_ext;
    end
    if (cmd_i.pop) begin
      depth_d = depth_m1;
      tos_d   = rd_q;
    end
    if (cmd_i.inv) tos_d = -tos_q;
    if (cmd_i.swap) begin
      wr_en   = 1'b1;
      wr_addr = depth_m2[csm_pkg::ADDR_W-1:0];
      tos_d   = rd_q;
    end
    if (cmd_i.commit) begin
      if (over) begin
        err_d = 1'b1;
      end else begin
        depth_d = depth_m1;
        tos_d   = res_q[csm_pkg::DATA_W-1:0];
      end
    end
  end

  assign fail = err_q | (depth_q != csm_pkg::DEPTH_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= csm_pkg::LIMIT_RESET;
    end else begin
      depth_q <= depth_d;
      err_q   <= err_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    res_q <= res_d;
    if (load_i) opnd_q <= operand_i;
    if (cmd_i.emit) begin
      out_data_q <= fail ? {1'b1, {csm_pkg::VAL_W{1'b0}}}
                         : {1'b0, tos_q[csm_pkg::VAL_W-1:0]};
    end
  end

  assign status_o.depth_zero = (depth_q == '0);
  assign status_o.depth_lt2  = (depth_q < csm_pkg::DEPTH_W'(2));
  assign status_o.depth_full = (depth_q == csm_pkg::DEPTH_W'(csm_pkg::STACK_DEPTH));
  assign status_o.err        = err_q;
  assign status_o.b_zero     = (tos_q == '0);
  assign status_o.div_done   = div_done;
  assign status_o.out_busy   = out_valid_q & ~m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

@@ design/csm_ctrl.sv @@
// Controller state machine: takes instructions, decodes them and sequences
// datapath commands. Depends on csm_pkg.
module csm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic [1:0]           req_type_i,
  input  logic [3:0]           opcode_i,
  input  csm_pkg::csm_status_t status_i,
  output logic                 s_tready_o,
  output logic                 load_o,
  output csm_pkg::csm_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEC  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_CHK  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] req_q;
  logic [3:0] op_q;

  // An end item waits while the previous report is still unclaimed.
  assign s_tready_o = (state_q == ST_IDLE) &&
                      !((req_type_i == csm_pkg::REQ_END) && status_i.out_busy);
  assign load_o     = s_tvalid_i & s_tready_o;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.is_mod = (op_q == csm_pkg::OP_MOD);
    unique case (state_q)
      ST_IDLE: if (load_o) state_d = ST_DEC;
      ST_DEC: begin
        state_d = ST_IDLE;
        priority case (req_q)
          csm_pkg::REQ_BEGIN: cmd_o.start_run = 1'b1;
          csm_pkg::REQ_END:   cmd_o.emit = 1'b1;
          csm_pkg::REQ_EXEC: begin
            if (!status_i.err) begin
              priority case (op_q)
                csm_pkg::OP_NUM: begin
                  if (status_i.depth_full) cmd_o.set_err = 1'b1;
                  else cmd_o.push = 1'b1;
                end
                csm_pkg::OP_POP: begin
                  if (status_i.depth_zero) cmd_o.set_err = 1'b1;
                  else cmd_o.pop = 1'b1;
                end
                csm_pkg::OP_INV: begin
                  if (status_i.depth_zero) cmd_o.set_err = 1'b1;
                  else cmd_o.inv = 1'b1;
                end
                csm_pkg::OP_DUP: begin
                  if (status_i.depth_zero || status_i.depth_full) cmd_o.set_err = 1'b1;
                  else begin
                    cmd_o.push     = 1'b1;
                    cmd_o.push_tos = 1'b1;
                  end
                end
                csm_pkg::OP_SWP: begin
                  if (status_i.depth_lt2) cmd_o.set_err = 1'b1;
                  else cmd_o.swap = 1'b1;
                end
                csm_pkg::OP_ADD, csm_pkg::OP_SUB, csm_pkg::OP_MUL: begin
                  if (status_i.depth_lt2) cmd_o.set_err = 1'b1;
                  else begin
                    cmd_o.add = (op_q == csm_pkg::OP_ADD);
                    cmd_o.sub = (op_q == csm_pkg::OP_SUB);
                    cmd_o.mul = (op_q == csm_pkg::OP_MUL);
                    state_d   = ST_CHK;
                  end
                end
                csm_pkg::OP_DIV, csm_pkg::OP_MOD: begin
                  if (status_i.depth_lt2 || status_i.b_zero) cmd_o.set_err = 1'b1;
                  else begin
                    cmd_o.div_start = 1'b1;
                    state_d         = ST_DIV;
                  end
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.div_fin = 1'b1;
          state_d       = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      req_q <= req_type_i;
      op_q  <= opcode_i;
    end
  end

endmodule

@@ design/checked_stack_machine.sv @@
// Checked stack machine: one instruction per transfer, one item at a time.
// Begin, end and simple opcodes pass through the decode state; ADD, SUB and MUL
// add the check state; DIV and MOD wait first for the one-bit-per-cycle divider.
// An end item's report is registered in the output register from the decode state.
// Reset clears depth, error flag and controller; the limit returns to 1000000000.
module checked_stack_machine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [3:0] opcode, [34:4] operand, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [30:0] result_value, [31] error
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i
);

  csm_pkg::csm_cmd_t    cmd;
  csm_pkg::csm_status_t status;
  logic                 load;

  csm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .req_type_i (s_axis_tuser),
    .opcode_i   (s_axis_tdata[3:0]),
    .status_i   (status),
    .s_tready_o (s_axis_tready),
    .load_o     (load),
    .cmd_o      (cmd)
  );

  csm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .load_i      (load),
    .operand_i   (s_axis_tdata[34:4]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tready_i  (m_axis_tready),
    .status_o    (status),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

@@ design/csm_checker.sv @@
// Port-level checks for the checked stack machine, bound to the top level.
// Depends on csm_pkg and checked_stack_machine.
module csm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic s_xfer, end_xfer;

  assign s_xfer   = s_axis_tvalid & s_axis_tready;
  assign end_xfer = s_xfer & (s_axis_tuser == csm_pkg::REQ_END);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[30:0] == 31'd0)
    else $error("error report carries a nonzero value");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready)
    else $error("input taken while an instruction is in flight");

  a_end_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_xfer |-> !m_axis_tvalid || m_axis_tready)
    else $error("end item taken while output is stalled");

  a_report_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(end_xfer, 2))
    else $error("report without an end item");

endmodule

bind checked_stack_machine csm_checker u_csm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
